[sv/pinv_pkg.sv]
// Package: widths, latencies, register map and shared types of the pseudo-inverse solve unit.
`default_nettype none
package pinv_pkg;

  localparam int DATA_W   = 32;
  localparam int FRAC     = 16;
  localparam int THR_W    = 31;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int TERM_W   = 98;
  localparam int ABS_W    = TERM_W - 1;
  localparam int NUM_W    = ABS_W + FRAC + 1;
  localparam int DEN_W    = ABS_W + 1;
  localparam int WIDE_W   = DEN_W + DATA_W;
  localparam int QBITS    = DATA_W;
  localparam int SQ_HALF  = 28;
  localparam int SQ_IN_W  = 2 * SQ_HALF;
  localparam int SQ_W     = 2 * SQ_IN_W;
  localparam int LIM_SHIFT = 5 * FRAC;

  localparam int FRONT_LAT = 7;
  localparam int DIV_LAT   = QBITS + 2;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT;
  localparam int SING_STG  = 9;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_THR_ADDR = 3'd0;
  localparam logic [THR_W-1:0]  THR_RESET    = 31'd1;

  // rotate tables for cross products
  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_in_t;

endpackage
`default_nettype wire

[sv/pinv_div.sv]
// Pipelined restoring divider: one quotient bit per stage, with rounding-safe saturation.
`default_nettype none
module pinv_div (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire pinv_pkg::div_in_t              din,
  output logic signed [pinv_pkg::DATA_W-1:0]  res
);

  localparam int QB = pinv_pkg::QBITS;

  logic [pinv_pkg::NUM_W-1:0]  r_r   [0:QB-1];
  logic [pinv_pkg::DEN_W-1:0]  b_r   [0:QB-1];
  logic [QB-1:0]               q_r   [0:QB];
  logic                        ovf_r [0:QB];
  logic                        neg_r [0:QB];
  logic signed [pinv_pkg::DATA_W-1:0] res_r;

  logic [pinv_pkg::WIDE_W-1:0] shf   [0:QB-1];
  logic                        ge    [0:QB-1];
  logic [pinv_pkg::NUM_W-1:0]  rsub  [0:QB-1];
  logic [QB-1:0]               sat;
  logic [QB-1:0]               mag;

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      shf[j]  = pinv_pkg::WIDE_W'(b_r[j]) << (QB - 1 - j);
      ge[j]   = pinv_pkg::WIDE_W'(r_r[j]) >= shf[j];
      rsub[j] = r_r[j] - pinv_pkg::NUM_W'(shf[j]);
    end
    sat = neg_r[QB] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
    mag = (ovf_r[QB] || (q_r[QB] > sat)) ? sat : q_r[QB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // entry: quotient beyond QB bits always saturates
      r_r[0]   <= din.num;
      b_r[0]   <= din.den;
      q_r[0]   <= '0;
      ovf_r[0] <= pinv_pkg::WIDE_W'(din.num) >= (pinv_pkg::WIDE_W'(din.den) << QB);
      neg_r[0] <= din.neg;
      for (int j = 0; j < QB - 1; j++) begin
        r_r[j+1] <= ge[j] ? rsub[j] : r_r[j];
        b_r[j+1] <= b_r[j];
      end
      for (int j = 0; j < QB; j++) begin
        q_r[j+1]   <= {q_r[j][QB-2:0], ge[j]};
        ovf_r[j+1] <= ovf_r[j];
        neg_r[j+1] <= neg_r[j];
      end
      res_r <= neg_r[QB] ? -$signed(mag) : $signed(mag);
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

[sv/pseudo_inverse_vec3_solve_unit.sv]
// Top level: streaming 3x3 pseudo-inverse solve, x = (A^T A)^-1 A^T v, Q16.16.
//
// Usage:
//   in_*  : one transfer carries the three columns of A and the vector v
//           (twelve signed Q16.16 words in in_tdata, col0_x in the lowest bits).
//   out_* : one transfer per input carries sol_x/y/z in out_tdata and the
//           singular flag in out_tuser; a singular item returns zeros.
//   cfg_* : APB write/read of singular_threshold at byte address 0.
// Timing: an input transfer passes through products, cross products and dot
//   products, magnitudes and divider operands (multipliers up to 32x33 bits,
//   one level per stage), the per-component divider (one quotient bit per
//   stage) and one output register. One item per cycle while not stalled.
// Reset: rst_n (synchronous, low) empties the pipeline, holds in_tready low
//   and sets the threshold to 1. Nothing else needs clearing.
// Stall: when out_tready is low, the result holds in the output register and
//   one more result lands in a skid register; only then does in_tready drop,
//   freezing the whole pipeline without loss until the skid drains.
`default_nettype none
module pseudo_inverse_vec3_solve_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // fields low to high: col0_x col0_y col0_z col1_x col1_y col1_z
  //                     col2_x col2_y col2_z rhs_x rhs_y rhs_z
  input  wire logic [383:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // fields low to high: sol_x sol_y sol_z
  output logic [95:0]       out_tdata,
  // fields low to high: singular
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [pinv_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int DW  = pinv_pkg::DATA_W;
  localparam int LAT = pinv_pkg::PIPE_LAT;
  localparam int SS  = pinv_pkg::SING_STG;

  // ---------------- configuration ----------------
  logic [pinv_pkg::THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= pinv_pkg::THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == pinv_pkg::REG_THR_ADDR) begin
      thr_r <= cfg_pwdata[pinv_pkg::THR_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == pinv_pkg::REG_THR_ADDR) ?
                      {1'b0, thr_r} : 32'd0;

  // ---------------- flow control ----------------
  logic en;
  logic skid_v_r;
  logic out_v_r;
  logic vld_r [1:LAT];

  // advance everything while the skid register is free
  assign en        = ~skid_v_r;
  assign in_tready = en && rst_n;

  // ---------------- stage 1: pair products of the cross products ----------------
  logic signed [DW-1:0] col_in [3][3];
  logic signed [DW-1:0] rhs_in [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        col_in[c][r] = $signed(in_tdata[(3*c+r)*DW +: DW]);
      end
      rhs_in[c] = $signed(in_tdata[(9+c)*DW +: DW]);
    end
  end

  // cross i: X0 = c1 x c2, X1 = c2 x c0, X2 = c0 x c1 (cofactor columns of A)
  logic signed [pinv_pkg::PROD_W-1:0]  pp_s1_r [3][3];
  logic signed [pinv_pkg::PROD_W-1:0]  pn_s1_r [3][3];
  logic signed [DW-1:0]                c0_s1_r [3];
  logic signed [DW-1:0]                v_s1_r  [3];

  // ---------------- stage 2: cross products ----------------
  logic signed [pinv_pkg::CROSS_W-1:0] x_s2_r  [3][3];
  logic signed [DW-1:0]                c0_s2_r [3];
  logic signed [DW-1:0]                v_s2_r  [3];

  // ---------------- stage 3: split 32x65 multiplies ----------------
  logic signed [DW-1:0]                mop     [12];
  logic signed [pinv_pkg::CROSS_W-1:0] top     [12];
  logic signed [pinv_pkg::CROSS_W-1:0] lo_s3_r [12];
  logic signed [pinv_pkg::CROSS_W-1:0] hi_s3_r [12];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mop[j] = c0_s2_r[j];
      top[j] = x_s2_r[0][j];
      for (int i = 0; i < 3; i++) begin
        mop[3+3*i+j] = v_s2_r[j];
        top[3+3*i+j] = x_s2_r[i][j];
      end
    end
  end

  // ---------------- stage 4..5: terms and dot products ----------------
  logic signed [pinv_pkg::TERM_W-1:0] term_s4_r [12];
  logic signed [pinv_pkg::TERM_W-1:0] det_s5_r;
  logic signed [pinv_pkg::TERM_W-1:0] num_s5_r [3];

  // ---------------- stage 6..7: magnitudes, divider operands, square ----------------
  logic [pinv_pkg::ABS_W-1:0] dm_s6_r;
  logic [pinv_pkg::ABS_W-1:0] nm_s6_r  [3];
  logic                       neg_s6_r [3];
  pinv_pkg::div_in_t          div_s7_r [3];
  logic                       big_s7_r;
  logic [pinv_pkg::SQ_IN_W-1:0] hh_s7_r;
  logic [pinv_pkg::SQ_IN_W-1:0] hl_s7_r;
  logic [pinv_pkg::SQ_IN_W-1:0] ll_s7_r;

  // ---------------- stage 8..9: determinant squared and singular test ----------------
  logic [pinv_pkg::SQ_W-1:0]  sq_s8_r;
  logic                       big_s8_r;
  logic                       sing_r [SS:LAT];
  logic [pinv_pkg::SQ_W-1:0]  lim;

  assign lim = pinv_pkg::SQ_W'(thr_r) << pinv_pkg::LIM_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_s1_r[i][j] <= col_in[pinv_pkg::NX1[i]][pinv_pkg::NX1[j]] *
                           col_in[pinv_pkg::NX2[i]][pinv_pkg::NX2[j]];
          pn_s1_r[i][j] <= col_in[pinv_pkg::NX1[i]][pinv_pkg::NX2[j]] *
                           col_in[pinv_pkg::NX2[i]][pinv_pkg::NX1[j]];
          x_s2_r[i][j]  <= pinv_pkg::CROSS_W'(pp_s1_r[i][j]) -
                           pinv_pkg::CROSS_W'(pn_s1_r[i][j]);
        end
        c0_s1_r[i] <= col_in[0][i];
        v_s1_r[i]  <= rhs_in[i];
        c0_s2_r[i] <= c0_s1_r[i];
        v_s2_r[i]  <= v_s1_r[i];
      end
      for (int k = 0; k < 12; k++) begin
        lo_s3_r[k]   <= mop[k] * $signed({1'b0, top[k][DW-1:0]});
        hi_s3_r[k]   <= mop[k] * $signed(top[k][pinv_pkg::CROSS_W-1:DW]);
        term_s4_r[k] <= (pinv_pkg::TERM_W'(hi_s3_r[k]) <<< DW) +
                        pinv_pkg::TERM_W'(lo_s3_r[k]);
      end
      det_s5_r <= term_s4_r[0] + term_s4_r[1] + term_s4_r[2];
      dm_s6_r  <= det_s5_r[pinv_pkg::TERM_W-1] ? pinv_pkg::ABS_W'(-det_s5_r)
                                               : pinv_pkg::ABS_W'(det_s5_r);
      for (int i = 0; i < 3; i++) begin
        num_s5_r[i] <= term_s4_r[3+3*i] + term_s4_r[4+3*i] + term_s4_r[5+3*i];
        nm_s6_r[i]  <= num_s5_r[i][pinv_pkg::TERM_W-1] ?
                       pinv_pkg::ABS_W'(-num_s5_r[i]) : pinv_pkg::ABS_W'(num_s5_r[i]);
        neg_s6_r[i] <= num_s5_r[i][pinv_pkg::TERM_W-1] ^ det_s5_r[pinv_pkg::TERM_W-1];
        // round half away: (|n| * 2^(F+1) + |d|) / (2 |d|)
        div_s7_r[i].num <= (pinv_pkg::NUM_W'(nm_s6_r[i]) << (pinv_pkg::FRAC + 1)) +
                           pinv_pkg::NUM_W'(dm_s6_r);
        div_s7_r[i].den <= {dm_s6_r, 1'b0};
        div_s7_r[i].neg <= neg_s6_r[i];
      end
      // |D| at or above 2^56 always clears the threshold
      big_s7_r <= |dm_s6_r[pinv_pkg::ABS_W-1:pinv_pkg::SQ_IN_W];
      hh_s7_r  <= dm_s6_r[pinv_pkg::SQ_IN_W-1:pinv_pkg::SQ_HALF] *
                  dm_s6_r[pinv_pkg::SQ_IN_W-1:pinv_pkg::SQ_HALF];
      hl_s7_r  <= dm_s6_r[pinv_pkg::SQ_IN_W-1:pinv_pkg::SQ_HALF] *
                  dm_s6_r[pinv_pkg::SQ_HALF-1:0];
      ll_s7_r  <= dm_s6_r[pinv_pkg::SQ_HALF-1:0] * dm_s6_r[pinv_pkg::SQ_HALF-1:0];
      sq_s8_r  <= (pinv_pkg::SQ_W'(hh_s7_r) << pinv_pkg::SQ_IN_W) +
                  (pinv_pkg::SQ_W'(hl_s7_r) << (pinv_pkg::SQ_HALF + 1)) +
                  pinv_pkg::SQ_W'(ll_s7_r);
      big_s8_r <= big_s7_r;
      sing_r[SS] <= ~big_s8_r && (sq_s8_r <= lim);
      for (int s = SS + 1; s <= LAT; s++) begin
        sing_r[s] <= sing_r[s-1];
      end
    end
  end

  // ---------------- dividers, one per component ----------------
  logic signed [DW-1:0] res [3];

  for (genvar g = 0; g < 3; g++) begin : g_div
    pinv_div u_div (
      .clk (clk),
      .en  (en),
      .din (div_s7_r[g]),
      .res (res[g])
    );
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= LAT; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[1] <= in_tvalid;
      for (int s = 2; s <= LAT; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // ---------------- output register and skid ----------------
  logic [95:0] pipe_d;
  logic        pipe_s;
  logic [95:0] out_d_r;
  logic        out_s_r;
  logic [95:0] skid_d_r;
  logic        skid_s_r;

  // drop the quotients of a singular item
  assign pipe_s = sing_r[LAT];
  assign pipe_d = pipe_s ? 96'd0 : {res[2], res[1], res[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (en) begin
      if (!out_v_r || out_tready) begin
        out_v_r <= vld_r[LAT];
      end else if (vld_r[LAT]) begin
        skid_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!out_v_r || out_tready) begin
        out_d_r <= pipe_d;
        out_s_r <= pipe_s;
      end else begin
        skid_d_r <= pipe_d;
        skid_s_r <= pipe_s;
      end
    end else if (out_tready) begin
      out_d_r <= skid_d_r;
      out_s_r <= skid_s_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_s_r;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a result while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid filled without an output stall");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_s_r) |-> (out_d_r == 96'd0))
    else $error("singular result carries nonzero data");

endmodule
`default_nettype wire

[bench/tb.sv]
// Testbench for the 3x3 pseudo-inverse solve unit: random and directed items, exact predictor.
`default_nettype none

class solve_scoreboard;
  typedef logic signed [255:0] wide_t;
  typedef struct {
    logic [31:0] sx, sy, sz;
    logic        sing;
  } solution_t;

  solution_t   pending[$];
  logic [30:0] threshold;
  int          mismatches;
  int          solved;
  int          singular_seen;

  function new();
    threshold     = 31'd1;
    mismatches    = 0;
    solved        = 0;
    singular_seen = 0;
  endfunction

  function void set_threshold(logic [31:0] value);
    threshold = value[30:0];
  endfunction

  // determinant of three columns: c0 . (c1 x c2)
  function wide_t det_cols(wide_t m[9]);
    wide_t t0, t1, t2;
    t0 = m[4] * m[8] - m[5] * m[7];
    t1 = m[1] * m[8] - m[2] * m[7];
    t2 = m[1] * m[5] - m[2] * m[4];
    return m[0] * t0 - m[3] * t1 + m[6] * t2;
  endfunction

  function solution_t solve_item(logic [383:0] item);
    wide_t       cols[9], rhs[3], repl[9];
    wide_t       det_a, det_n;
    logic [255:0] mag_d, mag_n, quot, limit;
    logic [31:0] res[3];
    logic        neg;
    solution_t   sol;
    for (int k = 0; k < 9; k++) cols[k] = $signed(item[32*k +: 32]);
    for (int k = 0; k < 3; k++) rhs[k] = $signed(item[32*(9+k) +: 32]);
    det_a = det_cols(cols);
    mag_d = det_a < 0 ? -det_a : det_a;
    limit = {225'd0, threshold} << 80;
    if (mag_d * mag_d <= limit) begin
      sol.sx = '0; sol.sy = '0; sol.sz = '0; sol.sing = 1'b1;
      return sol;
    end
    for (int i = 0; i < 3; i++) begin
      repl = cols;
      for (int r = 0; r < 3; r++) repl[3*i + r] = rhs[r];
      det_n = det_cols(repl);
      neg   = (det_n < 0) != (det_a < 0);
      mag_n = det_n < 0 ? -det_n : det_n;
      // round half away from zero, then clamp to the signed range
      quot  = ((mag_n << 17) + mag_d) / (mag_d << 1);
      if (neg && quot > 256'h8000_0000) quot = 256'h8000_0000;
      if (!neg && quot > 256'h7fff_ffff) quot = 256'h7fff_ffff;
      res[i] = neg ? -quot[31:0] : quot[31:0];
    end
    sol.sx = res[0]; sol.sy = res[1]; sol.sz = res[2]; sol.sing = 1'b0;
    return sol;
  endfunction

  function void note_input(logic [383:0] item);
    pending.push_back(solve_item(item));
  endfunction

  function void check_result(logic [95:0] data, logic sing);
    solution_t want;
    solved++;
    if (sing) singular_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h sing %b", data, sing);
      return;
    end
    want = pending.pop_front();
    if (data[31:0] !== want.sx || data[63:32] !== want.sy || data[95:64] !== want.sz ||
        sing !== want.sing) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected x %h y %h z %h sing %b, got x %h y %h z %h sing %b",
                 want.sx, want.sy, want.sz, want.sing,
                 data[31:0], data[63:32], data[95:64], sing);
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [383:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [pinv_pkg::ADDR_W-1:0] cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  solve_scoreboard solutions;

  // idle percentages of each side, and a long receiver hold-off in cycles
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int items_sent;

  pseudo_inverse_vec3_solve_unit dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watch both channels; record accepted inputs, check accepted results.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) solutions.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) solutions.check_result(out_tdata, out_tuser[0]);
  end

  // Receiver: a pending hold-off wins, else stall at random.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Write one register through a setup and an access cycle.
  task automatic write_threshold(logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= pinv_pkg::REG_THR_ADDR;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    solutions.set_threshold(value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Offer one item; hold it until the transfer happens.
  task automatic send_item(logic [383:0] item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_fields(logic [31:0] f[12]);
    logic [383:0] item;
    for (int k = 0; k < 12; k++) item[32*k +: 32] = f[k];
    send_item(item);
  endtask

  // Drop valid and wait for every expected result.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (solutions.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Any magnitude from a single bit up to the full range.
  function automatic logic [31:0] scaled_word();
    return $signed($urandom()) >>> $urandom_range(31);
  endfunction

  // Mostly well-conditioned systems, some near-singular, some diagonal, some raw noise.
  task automatic send_random();
    logic [31:0] f[12];
    int shape;
    shape = $urandom_range(99);
    for (int k = 0; k < 12; k++) f[k] = shape < 15 ? $urandom() : scaled_word();
    if (shape >= 15 && shape < 35) begin
      // third column nearly half the sum of the first two
      for (int r = 0; r < 3; r++)
        f[6+r] = ($signed(f[r]) >>> 1) + ($signed(f[3+r]) >>> 1) +
                 $signed($urandom_range(6)) - 3;
    end else if (shape >= 35 && shape < 45) begin
      // diagonal matrix, small entries push the solution toward the rails
      for (int k = 0; k < 9; k++) f[k] = '0;
      for (int r = 0; r < 3; r++) f[4*r] = $signed($urandom_range(65536 * 4)) - 131072;
    end
    send_fields(f);
  endtask

  task automatic send_directed();
    logic [31:0] f[12];
    logic [31:0] ends[4];
    ends = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
    // zero matrix: singular with a zero determinant
    foreach (f[k]) f[k] = '0;
    send_fields(f);
    // identity with extreme right-hand sides passes v through
    for (int e = 0; e < 4; e++) begin
      foreach (f[k]) f[k] = '0;
      f[0] = 32'h0001_0000; f[4] = 32'h0001_0000; f[8] = 32'h0001_0000;
      f[9] = ends[e]; f[10] = ends[(e+1)%4]; f[11] = ends[(e+2)%4];
      send_fields(f);
    end
    // tiny diagonal: saturate high and low
    for (int e = 0; e < 4; e++) begin
      foreach (f[k]) f[k] = '0;
      f[0] = 32'd2; f[4] = 32'd2; f[8] = 32'hffff_fffe;
      f[9] = ends[e]; f[10] = 32'd1; f[11] = ends[(e+3)%4];
      send_fields(f);
    end
    // every field at one extreme: rank one or zero, singular
    for (int e = 0; e < 4; e++) begin
      foreach (f[k]) f[k] = ends[e];
      send_fields(f);
    end
    // large well-separated diagonal
    foreach (f[k]) f[k] = '0;
    f[0] = 32'h7fff_ffff; f[4] = 32'h8000_0000; f[8] = 32'h7fff_ffff;
    f[9] = 32'h8000_0000; f[10] = 32'h7fff_ffff; f[11] = 32'h0001_0000;
    send_fields(f);
    // all-ones and alternating patterns with a signed permutation matrix
    foreach (f[k]) f[k] = '0;
    f[1] = 32'h0001_0000; f[5] = 32'hffff_0000; f[6] = 32'h0001_0000;
    f[9] = 32'hffff_ffff; f[10] = 32'h5555_5555; f[11] = 32'haaaa_aaaa;
    send_fields(f);
  endtask

  initial begin
    logic [31:0] thresholds[5];
    int          idle_modes[4][2];
    solutions       = new();
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    out_tready      = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    items_sent      = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset threshold first, then the directed set under a zero threshold
    send_directed();
    drain();
    write_threshold(32'd0);
    send_directed();
    drain();

    thresholds = '{32'd1, 32'h7fff_ffff, 32'h0001_0000, 32'hffff_ffff, $urandom()};
    idle_modes = '{'{0, 0}, '{66, 0}, '{0, 66}, '{26, 26}};
    for (int p = 0; p < 5; p++) begin
      write_threshold(thresholds[p]);
      for (int m = 0; m < 4; m++) begin
        send_idle_pct  = idle_modes[m][0];
        recv_stall_pct = idle_modes[m][1];
        // long receiver hold-off while the sender keeps offering
        if (p == 1 && m == 0) hold_off_cycles = 300;
        for (int n = 0; n < 100; n++) send_random();
      end
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
    $display("sent %0d systems, checked %0d solutions (%0d singular) over 7 thresholds",
             items_sent, solutions.solved, solutions.singular_seen);
    $display("idle patterns: none, sender, receiver, both; one 300-cycle receiver hold-off");
    if (solutions.mismatches == 0 && solutions.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", solutions.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
